/* hdl/mprx_pkg.sv */
`timescale 1ns / 1ps

package mprx_pkg;

    localparam int QUEUE_SLOTS  = 8;
    localparam int PACKET_BYTES = 32;
    localparam int SLOT_W       = $clog2(QUEUE_SLOTS);

    localparam logic [7:0] BROADCAST_ID = 8'hFF;
    localparam logic [5:0] HEADER_BYTES = 6'd4;
    localparam logic [5:0] LENGTH_POS   = 6'd2;

    typedef enum logic [1:0] {
        MODE_CHAR = 2'd0,
        MODE_FREE = 2'd1,
        MODE_TICK = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_NODE_ID     = 2'd0,
        CFG_STREAM_EN   = 2'd1,
        CFG_PULSE_TICKS = 2'd2
    } cfg_index_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  rx_byte;
        logic        nine_bit;
    } event_t;

    typedef struct packed {
        logic        store_enable;
        logic [2:0]  store_slot;
        logic [4:0]  store_index;
        logic [7:0]  store_byte;
        logic        packet_done;
        logic [5:0]  packet_length;
        logic        packet_dropped;
    } frame_res_t;

    typedef struct packed {
        logic        step_level;
        logic        dir_level;
        logic [31:0] position;
    } step_res_t;

endpackage

/* hdl/multidrop_packet_rx_step_dir.sv */
`timescale 1ns / 1ps

// channel   handshake               payload
// input     in_valid / in_ready     mode, rx_byte, nine_bit
// result    out_valid / out_ready   store_*, packet_*, step_level, dir_level, position
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one beat per cycle while in_ready is high; a result appears in the cycle after its input beat
// framer and stepper state update at the input beat, the result register holds the levels
// in_ready drops only while a result waits and out_ready is low
// reset clears framer, ring pointers, stepper and config to their defaults
// cfg_ready is always high; writes to an unused index are ignored

module multidrop_packet_rx_step_dir
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [7:0]         rx_byte,
    input  logic               nine_bit,

    output logic               out_valid,
    input  logic               out_ready,
    output logic               store_enable,
    output logic [2:0]         store_slot,
    output logic [4:0]         store_index,
    output logic [7:0]         store_byte,
    output logic               packet_done,
    output logic [5:0]         packet_length,
    output logic               packet_dropped,
    output logic               step_level,
    output logic               dir_level,
    output logic signed [31:0] position,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic        node_id_reg;
    logic [2:0]  node_id_val_reg;
    logic        stream_en_reg;
    logic [15:0] pulse_ticks_reg;

    logic                 fire;
    mprx_pkg::event_t     ev;
    mprx_pkg::frame_res_t frame_res;
    mprx_pkg::step_res_t  step_res;

    logic                 out_valid_reg;
    mprx_pkg::frame_res_t frame_reg;
    mprx_pkg::step_res_t  step_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;

    assign ev.mode     = mprx_pkg::mode_t'(mode);
    assign ev.rx_byte  = rx_byte;
    assign ev.nine_bit = nine_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg     <= 1'b0;
            node_id_val_reg <= 3'd1;
            stream_en_reg   <= 1'b0;
            pulse_ticks_reg <= 16'd100;
        end
        else if (cfg_valid)
        begin
            unique case (mprx_pkg::cfg_index_t'(cfg_index))
                mprx_pkg::CFG_NODE_ID:
                begin
                    node_id_val_reg <= cfg_data[2:0];
                    node_id_reg     <= 1'b1;
                end
                mprx_pkg::CFG_STREAM_EN:   stream_en_reg   <= cfg_data[0];
                mprx_pkg::CFG_PULSE_TICKS: pulse_ticks_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mprx_framer u_framer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .ev      (ev),
        .node_id (node_id_val_reg),
        .res     (frame_res)
    );

    mprx_stepper u_stepper
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .ev            (ev),
        .node_id       (node_id_val_reg),
        .stream_enable (stream_en_reg),
        .pulse_ticks   (pulse_ticks_reg),
        .res           (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            frame_reg <= frame_res;
            step_reg  <= step_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign store_enable   = frame_reg.store_enable;
    assign store_slot     = frame_reg.store_slot;
    assign store_index    = frame_reg.store_index;
    assign store_byte     = frame_reg.store_byte;
    assign packet_done    = frame_reg.packet_done;
    assign packet_length  = frame_reg.packet_length;
    assign packet_dropped = frame_reg.packet_dropped;
    assign step_level     = step_reg.step_level;
    assign dir_level      = step_reg.dir_level;
    assign position       = step_reg.position;

    // node id written at least once is tracked only for the check below
    a_done_stores: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_done |-> store_enable)
        else $error("completed packet without a stored byte");

    a_store_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(store_enable && packet_dropped))
        else $error("byte both stored and dropped");

    a_non_char_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (mode != mprx_pkg::MODE_CHAR) |=> !store_enable && !packet_dropped)
        else $error("store activity from a non-character beat");

    a_node_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        !node_id_reg |-> node_id_val_reg == 3'd1)
        else $error("node id changed without a config beat");

endmodule

/* hdl/mprx_framer.sv */
`timescale 1ns / 1ps

module mprx_framer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  mprx_pkg::event_t    ev,
    input  logic [2:0]          node_id,
    output mprx_pkg::frame_res_t res
);

    logic                        in_packet_reg, in_packet_next;
    logic                        dropping_reg, dropping_next;
    logic [5:0]                  byte_count_reg, byte_count_next;
    logic [mprx_pkg::SLOT_W-1:0] head_reg, head_next;
    logic [mprx_pkg::SLOT_W-1:0] tail_reg, tail_next;
    logic [7:0]                  length_reg, length_next;

    logic [mprx_pkg::SLOT_W-1:0] head_inc;
    logic [mprx_pkg::SLOT_W-1:0] tail_inc;
    logic [5:0]                  bc_eff;
    logic [5:0]                  bc_inc;
    logic [7:0]                  len_eff;
    logic                        drop_eff;
    logic                        is_cmd;
    logic                        is_stream;
    logic                        foreign;

    assign head_inc = (head_reg == mprx_pkg::SLOT_W'(mprx_pkg::QUEUE_SLOTS - 1))
                      ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == mprx_pkg::SLOT_W'(mprx_pkg::QUEUE_SLOTS - 1))
                      ? '0 : tail_reg + 1'b1;

    assign is_cmd    = (ev.mode == mprx_pkg::MODE_CHAR) && ev.nine_bit;
    assign is_stream = (ev.mode == mprx_pkg::MODE_CHAR) && !ev.nine_bit;

    // a new packet starts with a fresh count
    assign bc_eff   = in_packet_reg ? byte_count_reg : '0;
    assign drop_eff = in_packet_reg ? dropping_reg : 1'b0;
    assign bc_inc   = bc_eff + 1'b1;
    assign len_eff  = (bc_eff == mprx_pkg::LENGTH_POS) ? ev.rx_byte : length_reg;
    assign foreign  = (ev.rx_byte != {5'd0, node_id}) && (ev.rx_byte != mprx_pkg::BROADCAST_ID);

    always_comb
    begin
        in_packet_next  = in_packet_reg;
        dropping_next   = dropping_reg;
        byte_count_next = byte_count_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        length_next     = length_reg;
        res             = '0;

        if (is_cmd)
        begin
            in_packet_next  = 1'b1;
            dropping_next   = drop_eff;
            byte_count_next = bc_eff;
            if (drop_eff || (head_inc == tail_reg)
                || (bc_eff >= 6'(mprx_pkg::PACKET_BYTES)))
            begin
                res.packet_dropped = 1'b1;
            end
            else if ((bc_eff == '0) && foreign)
            begin
                dropping_next      = 1'b1;
                res.packet_dropped = 1'b1;
            end
            else
            begin
                res.store_enable = 1'b1;
                res.store_slot   = 3'(head_reg);
                res.store_index  = bc_eff[4:0];
                res.store_byte   = ev.rx_byte;
                length_next      = len_eff;
                byte_count_next  = bc_inc;
                if ((bc_inc >= mprx_pkg::HEADER_BYTES)
                    && ({3'd0, bc_inc} == {3'd0, mprx_pkg::HEADER_BYTES} + {1'b0, len_eff}))
                begin
                    res.packet_done   = 1'b1;
                    res.packet_length = bc_inc;
                    head_next         = head_inc;
                    in_packet_next    = 1'b0;
                end
            end
        end
        else if (is_stream)
        begin
            in_packet_next = 1'b0;
            dropping_next  = 1'b0;
        end
        else if (ev.mode == mprx_pkg::MODE_FREE)
        begin
            if (tail_reg != head_reg)
            begin
                tail_next = tail_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg  <= 1'b0;
            dropping_reg   <= 1'b0;
            byte_count_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            length_reg     <= '0;
        end
        else if (fire)
        begin
            in_packet_reg  <= in_packet_next;
            dropping_reg   <= dropping_next;
            byte_count_reg <= byte_count_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            length_reg     <= length_next;
        end
    end

endmodule

/* hdl/mprx_stepper.sv */
`timescale 1ns / 1ps

module mprx_stepper
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  mprx_pkg::event_t     ev,
    input  logic [2:0]           node_id,
    input  logic                 stream_enable,
    input  logic [15:0]          pulse_ticks,
    output mprx_pkg::step_res_t  res
);

    logic        direction_reg, direction_next;
    logic        step_high_reg, step_high_next;
    logic [15:0] pulse_count_reg, pulse_count_next;
    logic [31:0] position_reg, position_next;

    logic [1:0]  pair;
    logic [2:0]  step_bit;
    logic [2:0]  dir_bit;

    // bit pair of this node, wraps past four nodes
    assign pair     = 2'(node_id - 3'd1);
    assign step_bit = {pair, 1'b0};
    assign dir_bit  = {pair, 1'b1};

    always_comb
    begin
        direction_next   = direction_reg;
        step_high_next   = step_high_reg;
        pulse_count_next = pulse_count_reg;
        position_next    = position_reg;

        case (ev.mode)
            mprx_pkg::MODE_CHAR:
            begin
                if (!ev.nine_bit && stream_enable)
                begin
                    direction_next = ev.rx_byte[dir_bit];
                    if (ev.rx_byte[step_bit])
                    begin
                        step_high_next   = 1'b1;
                        pulse_count_next = pulse_ticks;
                        position_next    = direction_next ? position_reg + 32'd1
                                                          : position_reg - 32'd1;
                    end
                end
            end
            mprx_pkg::MODE_TICK:
            begin
                if (step_high_reg)
                begin
                    if (pulse_count_reg <= 16'd1)
                    begin
                        pulse_count_next = '0;
                        step_high_next   = 1'b0;
                    end
                    else
                    begin
                        pulse_count_next = pulse_count_reg - 16'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        res.step_level = step_high_next;
        res.dir_level  = direction_next;
        res.position   = position_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= 1'b0;
            step_high_reg   <= 1'b0;
            pulse_count_reg <= '0;
            position_reg    <= '0;
        end
        else if (fire)
        begin
            direction_reg   <= direction_next;
            step_high_reg   <= step_high_next;
            pulse_count_reg <= pulse_count_next;
            position_reg    <= position_next;
        end
    end

endmodule

/* tb/sv/tb_multidrop_packet_rx_step_dir.sv */
`timescale 1ns / 1ps

module tb_multidrop_packet_rx_step_dir;
    import mprx_pkg::*;

    typedef struct packed {
        frame_res_t frame;
        step_res_t  step;
    } rx_result_t;

    localparam int IDLE_LIMIT = 2000;

    class rx_step_tracker;
        logic [2:0]  node_id;
        logic        stream_en;
        logic [15:0] pulse_ticks;
        logic        in_packet;
        logic        dropping;
        int          byte_count;
        int          head_slot;
        int          tail_slot;
        logic [7:0]  length_byte;
        logic        direction;
        logic        step_high;
        logic [15:0] pulse_count;
        logic [31:0] position_count;
        rx_result_t  pending_results[$];
        int          errors;

        function new();
            node_id = 3'd1;
            stream_en = 1'b0;
            pulse_ticks = 16'd100;
            in_packet = 1'b0;
            dropping = 1'b0;
            byte_count = 0;
            head_slot = 0;
            tail_slot = 0;
            length_byte = 8'd0;
            direction = 1'b0;
            step_high = 1'b0;
            pulse_count = 16'd0;
            position_count = 32'd0;
            errors = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] data);
            case (idx)
                CFG_NODE_ID:     node_id = data[2:0];
                CFG_STREAM_EN:   stream_en = data[0];
                CFG_PULSE_TICKS: pulse_ticks = data;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void note_event(mode_t m, logic [7:0] b, logic nb);
            rx_result_t r;
            int nxt;
            int sh;
            r = '0;
            case (m)
                MODE_CHAR:
                    if (nb)
                    begin
                        if (!in_packet)
                        begin
                            in_packet = 1'b1;
                            byte_count = 0;
                            dropping = 1'b0;
                        end
                        nxt = (head_slot + 1) % QUEUE_SLOTS;
                        if (dropping || nxt == tail_slot || byte_count >= PACKET_BYTES)
                            r.frame.packet_dropped = 1'b1;
                        else if (byte_count == 0 && b != {5'd0, node_id} && b != BROADCAST_ID)
                        begin
                            dropping = 1'b1;
                            r.frame.packet_dropped = 1'b1;
                        end
                        else
                        begin
                            r.frame.store_enable = 1'b1;
                            r.frame.store_slot = 3'(head_slot);
                            r.frame.store_index = 5'(byte_count);
                            r.frame.store_byte = b;
                            if (byte_count == int'(LENGTH_POS))
                                length_byte = b;
                            byte_count++;
                            if (byte_count >= int'(HEADER_BYTES)
                                && byte_count == int'(HEADER_BYTES) + int'(length_byte))
                            begin
                                r.frame.packet_done = 1'b1;
                                r.frame.packet_length = 6'(byte_count);
                                head_slot = nxt;
                                in_packet = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        in_packet = 1'b0;
                        dropping = 1'b0;
                        if (stream_en)
                        begin
                            sh = ((int'(node_id) + 3) % 4) * 2;
                            direction = b[sh + 1];
                            if (b[sh])
                            begin
                                step_high = 1'b1;
                                position_count = direction ? position_count + 32'd1
                                                           : position_count - 32'd1;
                                pulse_count = pulse_ticks;
                            end
                        end
                    end
                MODE_FREE:
                    if (tail_slot != head_slot)
                        tail_slot = (tail_slot + 1) % QUEUE_SLOTS;
                MODE_TICK:
                    if (step_high)
                    begin
                        if (pulse_count <= 16'd1)
                        begin
                            pulse_count = 16'd0;
                            step_high = 1'b0;
                        end
                        else
                            pulse_count--;
                    end
                default: ;
            endcase
            r.step.step_level = step_high;
            r.step.dir_level = direction;
            r.step.position = position_count;
            pending_results.push_back(r);
        endfunction

        function string show(rx_result_t r);
            return $sformatf({"en=%0d slot=%0d idx=%0d byte=%02h done=%0d len=%0d",
                              " drop=%0d step=%0d dir=%0d pos=%08h"},
                r.frame.store_enable, r.frame.store_slot, r.frame.store_index,
                r.frame.store_byte, r.frame.packet_done, r.frame.packet_length,
                r.frame.packet_dropped, r.step.step_level, r.step.dir_level, r.step.position);
        endfunction

        function void flag(string what, rx_result_t e, rx_result_t got);
            errors++;
            if (errors <= 10)
                $display("%s\n  expected %s\n  actual   %s", what, show(e), show(got));
        endfunction

        function void check_result(rx_result_t got);
            rx_result_t e;
            string bad;
            if (pending_results.size() == 0)
            begin
                flag("result with nothing pending", '0, got);
                return;
            end
            e = pending_results.pop_front();
            bad = "";
            if (got.frame.store_enable !== e.frame.store_enable) bad = {bad, " store_enable"};
            if (got.frame.store_slot !== e.frame.store_slot) bad = {bad, " store_slot"};
            if (got.frame.store_index !== e.frame.store_index) bad = {bad, " store_index"};
            if (got.frame.store_byte !== e.frame.store_byte) bad = {bad, " store_byte"};
            if (got.frame.packet_done !== e.frame.packet_done) bad = {bad, " packet_done"};
            if (got.frame.packet_length !== e.frame.packet_length)
                bad = {bad, " packet_length"};
            if (got.frame.packet_dropped !== e.frame.packet_dropped)
                bad = {bad, " packet_dropped"};
            if (got.step.step_level !== e.step.step_level) bad = {bad, " step_level"};
            if (got.step.dir_level !== e.step.dir_level) bad = {bad, " dir_level"};
            if (got.step.position !== e.step.position) bad = {bad, " position"};
            if (bad != "")
                flag($sformatf("mismatch on%s", bad), e, got);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = MODE_NONE;
    logic [7:0]  rx_byte = 8'd0;
    logic        nine_bit = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b1;
    logic        store_enable;
    logic [2:0]  store_slot;
    logic [4:0]  store_index;
    logic [7:0]  store_byte;
    logic        packet_done;
    logic [5:0]  packet_length;
    logic        packet_dropped;
    logic        step_level;
    logic        dir_level;
    logic signed [31:0] position;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_NODE_ID;
    logic [15:0] cfg_data = 16'd0;

    logic        in_take = 1'b0;
    logic        out_take = 1'b0;
    logic        cfg_take = 1'b0;
    rx_result_t  out_seen;
    bit          send_gaps = 1'b1;
    bit          recv_gaps = 1'b1;
    int          sent = 0;
    int          idle_cycles = 0;

    rx_step_tracker tracker;

    multidrop_packet_rx_step_dir uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .rx_byte(rx_byte),
        .nine_bit(nine_bit),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .store_enable(store_enable),
        .store_slot(store_slot),
        .store_index(store_index),
        .store_byte(store_byte),
        .packet_done(packet_done),
        .packet_length(packet_length),
        .packet_dropped(packet_dropped),
        .step_level(step_level),
        .dir_level(dir_level),
        .position(position),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // handshakes and result fields are taken mid-cycle, used at the next rising edge
    always @(negedge clk)
    begin
        in_take = rst_n && in_valid && in_ready;
        out_take = rst_n && out_valid && out_ready;
        cfg_take = rst_n && cfg_valid && cfg_ready;
        out_seen.frame = {store_enable, store_slot, store_index, store_byte,
                          packet_done, packet_length, packet_dropped};
        out_seen.step = {step_level, dir_level, position};
    end

    always @(posedge clk)
    begin
        if (out_take)
            tracker.check_result(out_seen);
        if (in_take || out_take || cfg_take)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (recv_gaps && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_event(mode_t m, logic [7:0] b, logic nb);
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        rx_byte <= b;
        nine_bit <= nb;
        @(posedge clk);
        while (!in_take) @(posedge clk);
        tracker.note_event(m, b, nb);
        if (m != MODE_NONE)
            sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.outstanding() != 0);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_take) @(posedge clk);
        tracker.write_reg(idx, d);
    endtask

    task automatic set_config(logic [2:0] nid, logic en, logic [15:0] ticks);
        write_reg(CFG_NODE_ID, {13'd0, nid});
        write_reg(CFG_STREAM_EN, {15'd0, en});
        write_reg(CFG_PULSE_TICKS, ticks);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_packet();
        logic [7:0] dest;
        logic [7:0] len;
        logic [7:0] b;
        int pick;
        int total;
        int cut;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            dest = {5'd0, tracker.node_id};
        else if (pick < 8)
            dest = BROADCAST_ID;
        else
            dest = 8'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            len = 8'($urandom_range(29, 255));
        else if (pick == 1)
            len = 8'd28;
        else
            len = 8'($urandom_range(0, 8));
        total = 4 + int'(len);
        if (total > 36)
            total = 33 + $urandom_range(0, 3);
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : total;
        for (int i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_event($urandom_range(0, 1) ? MODE_TICK : MODE_FREE, 8'($urandom), 1'($urandom));
            b = (i == 0) ? dest : (i == 2) ? len : 8'($urandom);
            send_event(MODE_CHAR, b, 1'b1);
        end
        // overlong or cut-short packets need a stream char to restart the framer
        if (cut < total || len > 8'd28)
            send_event(MODE_CHAR, 8'($urandom), 1'b0);
    endtask

    task automatic run_phase(int items);
        int target;
        int r;
        target = sent + items;
        while (sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                drain_results();
            if (r < 50)
                send_packet();
            else if (r < 62)
                send_event(MODE_CHAR, 8'($urandom), 1'b0);
            else if (r < 76)
                repeat ($urandom_range(1, 4)) send_event(MODE_FREE, 8'($urandom), 1'($urandom));
            else if (r < 88)
                repeat ($urandom_range(1, 6)) send_event(MODE_TICK, 8'($urandom), 1'($urandom));
            else
                send_event(mode_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: stream chars ignored, node 1
        send_event(MODE_CHAR, 8'h00, 1'b0);
        send_event(MODE_CHAR, 8'h01, 1'b1);
        send_event(MODE_CHAR, 8'hAA, 1'b1);
        send_event(MODE_CHAR, 8'h00, 1'b1);
        send_event(MODE_CHAR, 8'h55, 1'b1);
        send_event(MODE_CHAR, BROADCAST_ID, 1'b1);
        send_event(MODE_CHAR, 8'h00, 1'b1);
        send_event(MODE_CHAR, 8'h01, 1'b1);
        send_event(MODE_CHAR, 8'hFF, 1'b1);
        send_event(MODE_CHAR, 8'h80, 1'b1);
        send_event(MODE_CHAR, 8'h02, 1'b1);
        send_event(MODE_CHAR, 8'h33, 1'b1);
        send_event(MODE_CHAR, 8'hFF, 1'b0);
        send_event(MODE_FREE, 8'h00, 1'b0);
        send_event(MODE_FREE, 8'hFF, 1'b1);
        send_event(MODE_FREE, 8'h00, 1'b0);
        send_event(MODE_TICK, 8'h00, 1'b0);
        send_event(MODE_NONE, 8'hFF, 1'b1);
        drain_results();

        // zero pulse length, step backward across zero, step while high
        set_config(3'd1, 1'b1, 16'd0);
        send_event(MODE_CHAR, 8'h01, 1'b0);
        send_event(MODE_CHAR, 8'h03, 1'b0);
        send_event(MODE_TICK, 8'h00, 1'b0);
        drain_results();

        set_config(3'd2, 1'b1, 16'd1);
        run_phase(100);
        drain_results();
        set_config(3'd4, 1'b1, 16'hFFFF);
        run_phase(100);
        drain_results();
        set_config(3'd3, 1'b0, 16'd5);
        run_phase(100);
        drain_results();
        set_config(3'd7, 1'b1, 16'd3);
        run_phase(100);
        drain_results();
        set_config(3'd0, 1'b1, 16'd2);
        run_phase(100);
        drain_results();

        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        set_config(3'd1, 1'b1, 16'($urandom_range(1, 8)));
        run_phase(100);
        drain_results();
        repeat (4) @(posedge clk);

        if (tracker.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
hdl/mprx_pkg.sv
hdl/mprx_framer.sv
hdl/mprx_stepper.sv
hdl/multidrop_packet_rx_step_dir.sv
tb/sv/tb_multidrop_packet_rx_step_dir.sv
